// ----- rtl/fwlm_pkg.sv -----
// fwlm_pkg: shared constants, types and helpers for the first windowed local
// minimum detector. No dependencies; used by every file in rtl/.

package fwlm_pkg;

  localparam int MAX_WINDOW  = 7;
  localparam int MAX_ITEMS   = 65536;
  // Port sample width is fixed at 32; only the low SAMPLE_BITS are used.
  localparam int SAMPLE_W    = 32;
  localparam int SAMPLE_BITS = 32;
  localparam int HIST_DEPTH  = 2 * MAX_WINDOW + 1;
  localparam int WIN_W       = 3;
  localparam int AGE_W       = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int POS_W       = 17;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAST_WINDOW   = 1'b0,
    REG_FUTURE_WINDOW = 1'b1
  } cfg_reg_t;

  // One history slot. Relation bits at offset m (bit m-1) compare this sample
  // with the one m slots older.
  typedef struct packed {
    logic                   valid;
    logic [SAMPLE_BITS-1:0] smp;
    logic [HIST_DEPTH-2:0]  older_gt;   // older sample > this one
    logic [HIST_DEPTH-2:0]  older_lt;   // older sample < this one
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [AGE_W-1:0] age;  // age of the winning candidate
  } verdict_t;

  function automatic logic [AGE_W-1:0] cap_window(logic [WIN_W-1:0] w);
    logic [AGE_W-1:0] r;
    if (w > MAX_WINDOW) begin
      r = AGE_W'(MAX_WINDOW);
    end else begin
      r = AGE_W'(w);
    end
    return r;
  endfunction

endpackage

// ----- rtl/fwlm_cell.sv -----
// fwlm_cell: one history slot of the sample window. Holds a sample, its valid
// bit and its relations to older slots; compares itself with the incoming word.
// Depends on fwlm_pkg.

module fwlm_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic                            clear,
  input  fwlm_pkg::entry_t                d_in,
  input  logic [fwlm_pkg::SAMPLE_BITS-1:0] new_smp,
  output fwlm_pkg::entry_t                q,
  output logic                            cmp_gt,  // stored > incoming
  output logic                            cmp_lt   // stored < incoming
);

  fwlm_pkg::entry_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (clear) begin
      slot.valid <= 1'b0;
    end else if (load) begin
      slot.valid <= d_in.valid;
    end
    if (load) begin
      slot.smp      <= d_in.smp;
      slot.older_gt <= d_in.older_gt;
      slot.older_lt <= d_in.older_lt;
    end
  end

  assign q      = slot;
  assign cmp_gt = slot.smp > new_smp;
  assign cmp_lt = slot.smp < new_smp;

endmodule

// ----- rtl/fwlm_judge.sv -----
// fwlm_judge: tests the candidate slots of the window against their neighbors
// and picks the one to report. Depends on fwlm_pkg.

module fwlm_judge (
  input  fwlm_pkg::entry_t                win [fwlm_pkg::HIST_DEPTH],
  input  logic [fwlm_pkg::AGE_W-1:0]      pw,
  input  logic [fwlm_pkg::AGE_W-1:0]      fw,
  input  logic                            last,
  output fwlm_pkg::verdict_t              verdict
);

  logic [fwlm_pkg::MAX_WINDOW:0] qual;

  // Candidate at age d: newer slots and up to pw older slots must be larger.
  always_comb begin
    for (int d = 0; d <= fwlm_pkg::MAX_WINDOW; d++) begin
      qual[d] = win[d].valid;
      for (int k = 0; k < fwlm_pkg::HIST_DEPTH; k++) begin
        if (k < d) begin
          if (win[k].valid && !win[k].older_lt[d-k-1]) begin
            qual[d] = 1'b0;
          end
        end else if (k > d && k <= d + int'(pw)) begin
          if (win[k].valid && !win[d].older_gt[k-d-1]) begin
            qual[d] = 1'b0;
          end
        end
      end
    end
  end

  // Normal item: only the slot at age fw. End of stream: oldest waiting one.
  always_comb begin
    verdict.hit = 1'b0;
    verdict.age = fw;
    if (!last) begin
      verdict.hit = qual[fw];
    end else begin
      for (int d = 0; d <= fwlm_pkg::MAX_WINDOW; d++) begin
        if (d <= int'(fw) && qual[d]) begin
          verdict.hit = 1'b1;
          verdict.age = fwlm_pkg::AGE_W'(d);
        end
      end
    end
  end

endmodule

// ----- rtl/first_windowed_local_minimum_top.sv -----
// first_windowed_local_minimum_top: stream detector for the first strict local
// minimum over a configurable past/future window.
// Depends on fwlm_pkg, fwlm_cell, fwlm_judge.
//
// Usage:
//   in channel  (in_valid/in_ready): one sample word per item, last_sample
//     marks the end of a stream.
//   out channel (out_valid/out_ready): at most one word per stream, giving
//     the 1-based position and found; found=0 with position 0 at the last
//     item when nothing qualified.
//   cfg channel (cfg_valid/cfg_ready): index 0 past_window, 1 future_window;
//     always ready, write only while the block is idle.
// Throughput is one item per cycle while in_ready is high. The window is a
// row of 15 cells; each new word is compared against every cell in the cycle
// it is accepted, and the verdict is registered, so a result appears in the
// cycle after the item that causes it. in_ready drops only while a result is
// held and out_ready is low. Reset clears the window, the count, the reported
// flag and both window registers, with no clearing pass.
// After a report the rest of the stream is consumed without output.

module first_windowed_local_minimum_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fwlm_pkg::SAMPLE_W-1:0]      sample,
  input  logic                               last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fwlm_pkg::POS_W-1:0]         position,
  output logic                               found,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fwlm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fwlm_pkg::WIN_W-1:0]         cfg_data
);

  localparam int HD = fwlm_pkg::HIST_DEPTH;

  logic [fwlm_pkg::WIN_W-1:0] past_window;
  logic [fwlm_pkg::WIN_W-1:0] future_window;
  logic [fwlm_pkg::CNT_W-1:0] sample_count;
  logic                       reported;

  logic                       accept;
  logic                       can_shift;
  logic                       do_shift;
  logic                       do_clear;
  logic                       emit;
  logic [fwlm_pkg::CNT_W-1:0] count_post;
  logic [fwlm_pkg::SAMPLE_BITS-1:0] new_smp;

  fwlm_pkg::entry_t  cur  [HD];
  fwlm_pkg::entry_t  post [HD];
  fwlm_pkg::entry_t  new_entry;
  logic [HD-1:0]     cmp_gt;
  logic [HD-1:0]     cmp_lt;
  fwlm_pkg::verdict_t verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      past_window   <= '0;
      future_window <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fwlm_pkg::REG_PAST_WINDOW:   past_window   <= cfg_data;
        fwlm_pkg::REG_FUTURE_WINDOW: future_window <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign new_smp   = sample[fwlm_pkg::SAMPLE_BITS-1:0];
  assign can_shift = sample_count < fwlm_pkg::CNT_W'(fwlm_pkg::MAX_ITEMS);
  assign do_shift  = accept && !reported && can_shift;
  assign do_clear  = accept && last_sample;
  assign count_post = can_shift ? sample_count + 1'b1 : sample_count;

  // Incoming word as the newest slot, with its relations to the older ones.
  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.smp   = new_smp;
    for (int m = 1; m < HD; m++) begin
      new_entry.older_gt[m-1] = cmp_gt[m-1];
      new_entry.older_lt[m-1] = cmp_lt[m-1];
    end
  end

  // Window as it stands after this item.
  always_comb begin
    for (int k = 0; k < HD; k++) begin
      if (!can_shift) begin
        post[k] = cur[k];
      end else if (k == 0) begin
        post[k] = new_entry;
      end else begin
        post[k] = cur[k-1];
      end
    end
  end

  for (genvar g = 0; g < HD; g++) begin : g_cell
    fwlm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .load    (do_shift),
      .clear   (do_clear),
      .d_in    (post[g]),
      .new_smp (new_smp),
      .q       (cur[g]),
      .cmp_gt  (cmp_gt[g]),
      .cmp_lt  (cmp_lt[g])
    );
  end

  fwlm_judge u_judge (
    .win     (post),
    .pw      (fwlm_pkg::cap_window(past_window)),
    .fw      (fwlm_pkg::cap_window(future_window)),
    .last    (last_sample),
    .verdict (verdict)
  );

  // A normal item reports only on a hit; the last item reports unless the stream already has.
  assign emit = accept && !reported &&
                (last_sample || (can_shift && verdict.hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      reported     <= 1'b0;
    end else if (do_clear) begin
      sample_count <= '0;
      reported     <= 1'b0;
    end else if (accept && !reported) begin
      sample_count <= count_post;
      if (emit) begin
        reported <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found <= verdict.hit;
      if (verdict.hit) begin
        position <= fwlm_pkg::POS_W'(count_post -
                    fwlm_pkg::CNT_W'(verdict.age));
      end else begin
        position <= '0;
      end
    end
  end

endmodule
